### hdl/mdac_pkg.sv
// Shared types and constants for the array address calculator.
// No dependencies; imported by the top level, the sequencer and the bench.
`timescale 1ns / 1ps

package mdac_pkg;

  localparam int NUM_ARRAYS_DEF = 16;
  localparam int MAX_DIMS_DEF   = 10;

  localparam int ID_W    = 4;
  localparam int POS_W   = 4;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 4;
  localparam int REQ_W   = 2;
  localparam int S_DATA_W = 80;  // 76 bits of fields, padded to bytes
  localparam int M_DATA_W = 40;  // 36 bits of fields, padded to bytes

  typedef enum logic [REQ_W-1:0] {
    REQ_HEADER = 2'd0,
    REQ_BOUNDS = 2'd1,
    REQ_INDEX  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE
  } state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_word;    // input word accepted this cycle
    logic start_idx;  // accepted word is a subscript that needs the tables
    logic last_dim;   // subscript in flight is the last one of its array
    logic out_free;   // output register can take a word this cycle
  } sts_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic mac_en;
    logic scale_en;
  } ctl_t;

endpackage

### hdl/multidim_array_address_calc.sv
// Header and bound words are written in the accept cycle. A subscript passes the registered
// descriptor RAM read, then the offset multiply-add; the last subscript of an array also
// takes the scale step (scale by element size) before the address word is shown.
// Header/bound words are taken one word per cycle while no subscript is in flight; no new
// word is taken until a subscript has finished its multiply-add and, for the last one, the
// scale step, which holds while an earlier address word waits on m_tready.
// Reset (rst, synchronous): sequencer to idle, output empty, offset zero; tables keep contents.
`timescale 1ns / 1ps

module multidim_array_address_calc #(
  parameter int NUM_ARRAYS = mdac_pkg::NUM_ARRAYS_DEF,
  parameter int MAX_DIMS   = mdac_pkg::MAX_DIMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input word.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, from bit 0: array_id[4], dim_pos[4], value_a[32], value_b[32],
  // dim_count[4], zero pad[4]
  input  logic [mdac_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser: req_type[2]
  input  logic [mdac_pkg::REQ_W-1:0]    s_tuser,
  // Result word.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, from bit 0: address[32], array_ref[4], zero pad[4]
  output logic [mdac_pkg::M_DATA_W-1:0] m_tdata
);

  import mdac_pkg::*;

  localparam int HAW  = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
  localparam int BDEP = NUM_ARRAYS * MAX_DIMS;
  localparam int BAW  = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int HDR_W = CNT_W + 2 * VAL_W;
  localparam int BND_W = 2 * VAL_W;

  // Unpack the input word.
  logic [ID_W-1:0]  in_id;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_va;
  logic [VAL_W-1:0] in_vb;
  logic [CNT_W-1:0] in_cnt;
  req_t             in_req;

  assign in_id  = s_tdata[3:0];
  assign in_pos = s_tdata[7:4];
  assign in_va  = s_tdata[39:8];
  assign in_vb  = s_tdata[71:40];
  assign in_cnt = s_tdata[75:72];
  assign in_req = req_t'(s_tuser);

  sts_t sts;
  ctl_t ctl;

  logic in_word;
  assign s_tready = ctl.in_ready;
  assign in_word  = s_tvalid && s_tready;

  // Decode which table the word touches; drop out-of-range ids and dimensions.
  logic [8:0]  id_ext;
  logic [11:0] slot_full;
  logic        id_ok;
  logic        pos_ok;
  logic        hdr_we;
  logic        bnd_we;
  logic        idx_go;

  assign id_ext    = 9'(in_id);
  assign slot_full = 12'(in_id) * 12'(MAX_DIMS) + 12'(in_pos) - 12'd1;
  assign id_ok     = id_ext < 9'(NUM_ARRAYS);
  assign pos_ok    = in_pos inside {[POS_W'(1):POS_W'(MAX_DIMS)]};

  always_comb begin
    hdr_we = 1'b0;
    bnd_we = 1'b0;
    idx_go = 1'b0;
    case (in_req)
      REQ_HEADER: hdr_we = in_word && id_ok;
      REQ_BOUNDS: bnd_we = in_word && id_ok && pos_ok;
      REQ_INDEX:  idx_go = in_word && id_ok && pos_ok;
      default: begin
        hdr_we = 1'b0;
      end
    endcase
  end

  // Clamp the dimension count into one to MAX_DIMS.
  logic [CNT_W-1:0] cnt_clamped;
  always_comb begin
    if (in_cnt == '0) begin
      cnt_clamped = CNT_W'(1);
    end else if (in_cnt > CNT_W'(MAX_DIMS)) begin
      cnt_clamped = CNT_W'(MAX_DIMS);
    end else begin
      cnt_clamped = in_cnt;
    end
  end

  // Tables are written only in the accept cycle and read only at a later accept,
  // so a read never overlaps a write of the same entry: no forwarding needed.
  logic [HDR_W-1:0] hdr_rd;
  logic [BND_W-1:0] bnd_rd;
  logic [VAL_W-1:0] extent_wr;

  assign extent_wr = in_vb - in_va + VAL_W'(1);

  mdac_ram #(
    .WIDTH(HDR_W),
    .DEPTH(NUM_ARRAYS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (hdr_we),
    .waddr(id_ext[HAW-1:0]),
    .wdata({cnt_clamped, in_vb, in_va}),
    .re   (idx_go),
    .raddr(id_ext[HAW-1:0]),
    .rdata(hdr_rd)
  );

  mdac_ram #(
    .WIDTH(BND_W),
    .DEPTH(BDEP)
  ) u_bnd_ram (
    .clk  (clk),
    .we   (bnd_we),
    .waddr(slot_full[BAW-1:0]),
    .wdata({extent_wr, in_va}),
    .re   (idx_go),
    .raddr(slot_full[BAW-1:0]),
    .rdata(bnd_rd)
  );

  logic [VAL_W-1:0] base_rd;
  logic [VAL_W-1:0] elem_rd;
  logic [CNT_W-1:0] dims_rd;
  logic [VAL_W-1:0] lower_rd;
  logic [VAL_W-1:0] extent_rd;

  assign base_rd   = hdr_rd[VAL_W-1:0];
  assign elem_rd   = hdr_rd[2*VAL_W-1:VAL_W];
  assign dims_rd   = hdr_rd[HDR_W-1:2*VAL_W];
  assign lower_rd  = bnd_rd[VAL_W-1:0];
  assign extent_rd = bnd_rd[BND_W-1:VAL_W];

  // Hold the subscript word while its table entries are read.
  logic [ID_W-1:0]  sub_id;
  logic [POS_W-1:0] sub_pos;
  logic [VAL_W-1:0] sub_va;

  always_ff @(posedge clk) begin
    if (idx_go) begin
      sub_id  <= in_id;
      sub_pos <= in_pos;
      sub_va  <= in_va;
    end
  end

  // Horner step: restart on dimension one, else offset * extent + term.
  logic [VAL_W-1:0] running_offset;
  logic [VAL_W-1:0] running_offset_next;
  logic [VAL_W-1:0] term;

  assign term = sub_va - lower_rd;

  always_comb begin
    if (sub_pos == POS_W'(1)) begin
      running_offset_next = term;
    end else begin
      running_offset_next = running_offset * extent_rd + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_offset <= '0;
    end else if (ctl.mac_en) begin
      running_offset <= running_offset_next;
    end
  end

  // Output register: scale by element size and add the base.
  logic             out_valid;
  logic [VAL_W-1:0] out_addr;
  logic [ID_W-1:0]  out_ref;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.scale_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scale_en) begin
      out_addr <= base_rd + running_offset * elem_rd;
      out_ref  <= sub_id;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_ref, out_addr};

  assign sts.in_word   = in_word;
  assign sts.start_idx = idx_go;
  assign sts.last_dim  = (sub_pos == dims_rd);
  assign sts.out_free  = !out_valid || m_tready;

  mdac_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .ctl(ctl)
  );

endmodule

### hdl/mdac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies; used for both descriptor tables.
`timescale 1ns / 1ps

module mdac_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/mdac_ctrl.sv
// Sequencer for the address calculator: idle, multiply-add, scale.
// Depends on mdac_pkg for the state enum and the status/control structs.
`timescale 1ns / 1ps

module mdac_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  mdac_pkg::sts_t sts,
  output mdac_pkg::ctl_t ctl
);

  import mdac_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.in_word && sts.start_idx) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        state_next = sts.last_dim ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE:  ctl.in_ready = 1'b1;
      ST_MAC:   ctl.mac_en   = 1'b1;
      ST_SCALE: ctl.scale_en = sts.out_free;
      default:  ctl = '0;
    endcase
  end

endmodule

### tb/tb.sv
// Self-checking bench for multidim_array_address_calc: loads array descriptors,
// streams subscripts and checks every address word against a built-in predictor.
// Depends on mdac_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb;
  import mdac_pkg::*;

  localparam int NARR   = NUM_ARRAYS_DEF;
  localparam int NDIM   = MAX_DIMS_DEF;
  localparam int NSLOT  = NARR * NDIM;
  localparam int SLOT_W = $clog2(NSLOT);

  // Request code that the block has no use for; it must drop such words.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RAND_ITEMS   = 2000;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 20;

  // One input word, unpacked.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] va;
    logic [VAL_W-1:0] vb;
    logic [CNT_W-1:0] cnt;
  } word_t;

  // One expected address word.
  typedef struct packed {
    logic [VAL_W-1:0] addr;
    logic [ID_W-1:0]  id;
  } addr_t;

  // Descriptor tables, the running Horner offset and the queue of addresses
  // still owed by the block.
  class addr_scoreboard;
    logic [VAL_W-1:0] base_tbl [NARR];
    logic [VAL_W-1:0] elem_tbl [NARR];
    logic [CNT_W-1:0] dims_tbl [NARR];
    logic [VAL_W-1:0] lower_tbl [NSLOT];
    logic [VAL_W-1:0] extent_tbl [NSLOT];
    logic [VAL_W-1:0] offset;
    addr_t            addr_q [$];
    int               errors;
    int               checked;

    function new();
      offset  = '0;
      errors  = 0;
      checked = 0;
    endfunction

    // Apply one accepted input word; queue an address when it closes an access.
    function void note_word(word_t w);
      logic [SLOT_W-1:0] slot;
      logic [VAL_W-1:0]  term;
      addr_t             a;
      if (w.req == REQ_HEADER) begin
        base_tbl[w.id] = w.va;
        elem_tbl[w.id] = w.vb;
        if (w.cnt == 0) dims_tbl[w.id] = CNT_W'(1);
        else if (w.cnt > NDIM) dims_tbl[w.id] = CNT_W'(NDIM);
        else dims_tbl[w.id] = w.cnt;
        return;
      end
      if (w.req == REQ_UNUSED || w.pos == 0 || w.pos > NDIM) return;
      slot = SLOT_W'(w.id * NDIM + w.pos - 1);
      if (w.req == REQ_BOUNDS) begin
        lower_tbl[slot]  = w.va;
        extent_tbl[slot] = w.vb - w.va + 1;
        return;
      end
      term = w.va - lower_tbl[slot];
      if (w.pos == 1) offset = term;
      else offset = offset * extent_tbl[slot] + term;
      if (w.pos == dims_tbl[w.id]) begin
        a.addr = base_tbl[w.id] + offset * elem_tbl[w.id];
        a.id   = w.id;
        addr_q.push_back(a);
      end
    endfunction

    // Compare one accepted result word with the oldest expected address.
    function void check_word(logic [VAL_W-1:0] addr, logic [ID_W-1:0] id);
      addr_t a;
      if (addr_q.size() == 0) begin
        $display("%0t: unexpected address word: expected none, actual %h id %0d",
                 $time, addr, id);
        errors++;
        return;
      end
      a = addr_q.pop_front();
      checked++;
      if (addr !== a.addr) begin
        $display("%0t: address mismatch: expected %h, actual %h", $time, a.addr, addr);
        errors++;
      end
      if (id !== a.id) begin
        $display("%0t: array_ref mismatch: expected %0d, actual %0d", $time, a.id, id);
        errors++;
      end
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // s_tdata, from bit 0: array_id[4], dim_pos[4], value_a[32], value_b[32],
  // dim_count[4], zero pad[4]
  logic [S_DATA_W-1:0] s_tdata  = '0;
  // s_tuser: req_type[2]
  logic [REQ_W-1:0]    s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // m_tdata, from bit 0: address[32], array_ref[4], zero pad[4]
  logic [M_DATA_W-1:0] m_tdata;

  addr_scoreboard sb;

  // Stimulus-side view of which table entries hold data. A subscript is only
  // sent to a slot whose header and bounds were loaded, so the block never
  // reads an entry that was never written.
  bit               hdr_ok [NARR];
  bit               bnd_ok [NSLOT];
  int               dims_now [NARR];
  logic [VAL_W-1:0] lo_val [NSLOT];

  // When set, neither side idles: back-to-back words and m_tready held high.
  bit no_idle = 1'b0;

  int n_words, n_hdr, n_bnd, n_idx, n_drop, valid_items;
  int ready_left = 0;
  int idle_cycles = 0;

  multidim_array_address_calc dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: ready or stalled, chosen at random, in stretches of random length.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      if (no_idle) begin
        m_tready   <= 1'b1;
        ready_left <= 8;
      end else begin
        m_tready   <= $urandom_range(0, 2) != 0;
        ready_left <= gap_len() + 1;
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Check every result word at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_word(m_tdata[VAL_W-1:0], m_tdata[VAL_W +: ID_W]);
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d addresses outstanding",
                 $time, IDLE_LIMIT, sb.addr_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Drive one word: optional idle gap, then hold it until s_tready takes it.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                           input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] va,
                           input logic [VAL_W-1:0] vb, input logic [CNT_W-1:0] cnt);
    word_t w;
    int    gap;
    w   = '{req: req, id: id, pos: pos, va: va, vb: vb, cnt: cnt};
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, cnt, vb, va, pos, id};
    do @(posedge clk); while (!s_tready);
    sb.note_word(w);
    n_words++;
  endtask

  // Load a header and keep track of the stored dimension count.
  task automatic load_header(input logic [ID_W-1:0] id, input logic [VAL_W-1:0] base,
                             input logic [VAL_W-1:0] esize, input logic [CNT_W-1:0] cnt);
    send_word(REQ_HEADER, id, POS_W'($urandom), base, esize, cnt);
    hdr_ok[id]   = 1'b1;
    dims_now[id] = (cnt == 0) ? 1 : (cnt > NDIM) ? NDIM : cnt;
    n_hdr++;
    valid_items++;
  endtask

  task automatic load_bounds(input logic [ID_W-1:0] id, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
    logic [SLOT_W-1:0] slot;
    slot = SLOT_W'(id * NDIM + pos - 1);
    send_word(REQ_BOUNDS, id, pos, lo, hi, CNT_W'($urandom));
    bnd_ok[slot] = 1'b1;
    lo_val[slot] = lo;
    n_bnd++;
    valid_items++;
  endtask

  task automatic give_index(input logic [ID_W-1:0] id, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] idx);
    send_word(REQ_INDEX, id, pos, idx, VAL_W'($urandom), CNT_W'($urandom));
    n_idx++;
    valid_items++;
  endtask

  // Well-formed access: header and bounds (when needed, or at random), then subscripts 1..n.
  task automatic run_access();
    logic [ID_W-1:0]   id;
    logic [VAL_W-1:0]  lo, hi, esize, idx;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] slot;
    id = ID_W'($urandom);
    if (!hdr_ok[id] || $urandom_range(0, 4) == 0) begin
      cnt   = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 4));
      esize = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 16);
      load_header(id, $urandom, esize, cnt);
    end
    for (int d = 1; d <= dims_now[id]; d++) begin
      slot = SLOT_W'(id * NDIM + d - 1);
      if (!bnd_ok[slot] || $urandom_range(0, 3) == 0) begin
        lo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20) - 10;
        hi = ($urandom_range(0, 3) == 0) ? $urandom : lo + $urandom_range(0, 15);
        load_bounds(id, POS_W'(d), lo, hi);
      end
    end
    for (int d = 1; d <= dims_now[id]; d++) begin
      slot = SLOT_W'(id * NDIM + d - 1);
      idx  = ($urandom_range(0, 7) == 0) ? $urandom : lo_val[slot] + $urandom_range(0, 15);
      give_index(id, POS_W'(d), idx);
    end
  endtask

  // Noise: dropped words, stray loads and subscripts out of order.
  task automatic run_noise();
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
    logic [REQ_W-1:0] req;
    id = ID_W'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        send_word(REQ_UNUSED, id, POS_W'($urandom), $urandom, $urandom, CNT_W'($urandom));
        n_drop++;
      end
      1: begin
        // Dimension 0 or above the maximum: dropped, tables untouched.
        pos = POS_W'($urandom_range(0, 5));
        if (pos != 0) pos = POS_W'(pos + NDIM);
        req = $urandom_range(0, 1) ? REQ_BOUNDS : REQ_INDEX;
        send_word(req, id, pos, $urandom, $urandom, CNT_W'($urandom));
        n_drop++;
      end
      2: load_header(id, $urandom, $urandom, CNT_W'($urandom));
      3: load_bounds(id, POS_W'($urandom_range(1, NDIM)), $urandom, $urandom);
      default: begin
        // Subscript at any loaded slot: may continue a foreign offset, may sit
        // beyond the array's count, may close it.
        pos = POS_W'($urandom_range(1, NDIM));
        if (hdr_ok[id] && bnd_ok[SLOT_W'(id * NDIM + pos - 1)])
          give_index(id, pos, $urandom);
      end
    endcase
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A small 3-D array and a normal access through it.
    load_header(4'd0, 32'h0000_1000, 32'd4, 4'd3);
    load_bounds(4'd0, 4'd1, 32'd0, 32'd3);
    load_bounds(4'd0, 4'd2, -32'sd2, 32'd5);
    load_bounds(4'd0, 4'd3, 32'd1, 32'd4);
    give_index(4'd0, 4'd1, 32'd2);
    give_index(4'd0, 4'd2, 32'd0);
    give_index(4'd0, 4'd3, 32'd3);
    // Dropped words: unused request code, dimension 0, dimension above the maximum.
    send_word(REQ_UNUSED, 4'd0, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_word(REQ_BOUNDS, 4'd0, 4'd0, 32'd7, 32'd9, 4'd0);
    send_word(REQ_INDEX, 4'd0, 4'd15, 32'd1, 32'd0, 4'd0);
    n_drop += 3;
    // Extreme values; a zero count stored as one, extent wrapping to zero.
    load_header(4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 4'd0);
    load_bounds(4'd15, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    give_index(4'd15, 4'd1, 32'h7FFF_FFFF);
    // Later subscripts continue the offset left by another array.
    give_index(4'd0, 4'd2, 32'd4);
    give_index(4'd0, 4'd3, 32'h8000_0000);
    // Count above the maximum saturates; the tenth dimension closes it.
    load_header(4'd1, 32'd0, 32'hFFFF_FFFF, 4'd15);
    load_bounds(4'd1, 4'd10, -32'sd5, 32'd5);
    give_index(4'd0, 4'd1, 32'd1);
    give_index(4'd1, 4'd10, 32'd5);
    // Subscript beyond the array's count: offset moves, no address.
    load_bounds(4'd15, 4'd2, 32'd0, 32'hFFFF_FFFF);
    give_index(4'd15, 4'd1, 32'd0);
    give_index(4'd15, 4'd2, 32'd9);

    // Random part: mostly well-formed accesses, some noise, with stretches
    // where neither side idles.
    valid_items = 0;
    while (valid_items < RAND_ITEMS) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 9) < 7) run_access();
      else run_noise();
    end

    s_tvalid <= 1'b0;
    while (sb.addr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d headers, %0d bound loads, %0d subscripts, %0d dropped",
             n_words, n_hdr, n_bnd, n_idx, n_drop);
    $display("Checked %0d addresses, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.addr_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
